@@ sv/hsvck_pkg.sv @@
// hsvck_pkg: shared types and register indexes for the hsv range chroma key
`default_nettype none

package hsvck_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned HueW   = 9;
    localparam int unsigned CfgW   = 9;
    localparam int unsigned CfgIdxW = 3;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] RegHueMin = 3'd0;
    localparam logic [CfgIdxW-1:0] RegHueMax = 3'd1;
    localparam logic [CfgIdxW-1:0] RegSatMin = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSatMax = 3'd3;
    localparam logic [CfgIdxW-1:0] RegValMin = 3'd4;
    localparam logic [CfgIdxW-1:0] RegValMax = 3'd5;

    localparam logic [HueW-1:0]  HueMinRst = 9'd100;
    localparam logic [HueW-1:0]  HueMaxRst = 9'd185;
    localparam logic [ChanW-1:0] SatMinRst = 8'd80;
    localparam logic [ChanW-1:0] SatMaxRst = 8'd255;
    localparam logic [ChanW-1:0] ValMinRst = 8'd70;
    localparam logic [ChanW-1:0] ValMaxRst = 8'd255;

    typedef struct packed {
        logic [ChanW-1:0] alpha;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [HueW-1:0]  hue_min;
        logic [HueW-1:0]  hue_max;
        logic [ChanW-1:0] sat_min;
        logic [ChanW-1:0] sat_max;
        logic [ChanW-1:0] val_min;
        logic [ChanW-1:0] val_max;
    } key_cfg_t;

    // which channel is largest, red checked first
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

endpackage

`default_nettype wire

@@ sv/hsvck_pipe.sv @@
// hsvck_pipe: four-stage hsv conversion and range key datapath
`default_nettype none

module hsvck_pipe (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire hsvck_pkg::key_cfg_t  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hsvck_pkg::pixel_t    in_pix,
    input  wire logic                 in_last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hsvck_pkg::pixel_t         out_pix,
    output logic                      out_keyed,
    output logic                      out_last
);

    localparam int unsigned CW = hsvck_pkg::ChanW;

    // stage advance, each stage moves when empty or when the next one moves
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: largest and smallest channel, sector
    hsvck_pkg::pixel_t   pix1_reg;
    logic                last1_reg;
    logic [CW-1:0]       mx1_reg, mn1_reg;
    hsvck_pkg::sector_t  sec1_reg;

    logic [CW-1:0]       mx1_next, mn1_next;
    hsvck_pkg::sector_t  sec1_next;

    always_comb begin
        mx1_next = in_pix.red;
        mn1_next = in_pix.red;
        if (in_pix.green > mx1_next) mx1_next = in_pix.green;
        if (in_pix.blue  > mx1_next) mx1_next = in_pix.blue;
        if (in_pix.green < mn1_next) mn1_next = in_pix.green;
        if (in_pix.blue  < mn1_next) mn1_next = in_pix.blue;
        priority if (in_pix.red == mx1_next)   sec1_next = hsvck_pkg::SEC_RED;
        else if (in_pix.green == mx1_next)     sec1_next = hsvck_pkg::SEC_GREEN;
        else                                   sec1_next = hsvck_pkg::SEC_BLUE;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            pix1_reg  <= in_pix;
            last1_reg <= in_last;
            mx1_reg   <= mx1_next;
            mn1_reg   <= mn1_next;
            sec1_reg  <= sec1_next;
        end
    end

    // stage 2: chroma span and hue numerator before the factor of sixty
    hsvck_pkg::pixel_t   pix2_reg;
    logic                last2_reg;
    logic [CW-1:0]       mx2_reg, d2_reg;
    logic                grey2_reg;
    logic signed [11:0]  hn2_reg;

    logic [CW-1:0]       d2_next;
    logic signed [11:0]  hn2_next;
    logic signed [11:0]  r12, g12, b12, d12;

    always_comb begin
        d2_next = mx1_reg - mn1_reg;
        r12 = $signed({4'b0, pix1_reg.red});
        g12 = $signed({4'b0, pix1_reg.green});
        b12 = $signed({4'b0, pix1_reg.blue});
        d12 = $signed({4'b0, d2_next});
        unique case (sec1_reg)
            hsvck_pkg::SEC_RED:   hn2_next = g12 - b12;
            hsvck_pkg::SEC_GREEN: hn2_next = (d12 <<< 1) + b12 - r12;
            hsvck_pkg::SEC_BLUE:  hn2_next = (d12 <<< 2) + r12 - g12;
            default:              hn2_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            pix2_reg  <= pix1_reg;
            last2_reg <= last1_reg;
            mx2_reg   <= mx1_reg;
            d2_reg    <= d2_next;
            grey2_reg <= (d2_next == '0);
            hn2_reg   <= hn2_next;
        end
    end

    // stage 3: products for the cross-multiplied range checks
    hsvck_pkg::pixel_t   pix3_reg;
    logic                last3_reg;
    logic [CW-1:0]       mx3_reg;
    logic                grey3_reg;
    logic signed [17:0]  hn3_reg;
    logic [16:0]         hlo3_reg, hhi3_reg;
    logic [15:0]         snum3_reg, slo3_reg, shi3_reg;

    logic signed [17:0]  hn3_next;
    logic [16:0]         hlo3_next, hhi3_next;
    logic [15:0]         snum3_next, slo3_next, shi3_next;

    always_comb begin
        hn3_next   = 18'(signed'({{6{hn2_reg[11]}}, hn2_reg}) * 18'sd60);
        hlo3_next  = 17'(cfg.hue_min) * 17'(d2_reg);
        hhi3_next  = 17'(cfg.hue_max) * 17'(d2_reg);
        snum3_next = {d2_reg, 8'b0} - 16'(d2_reg);
        slo3_next  = 16'(cfg.sat_min) * 16'(mx2_reg);
        shi3_next  = 16'(cfg.sat_max) * 16'(mx2_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            pix3_reg  <= pix2_reg;
            last3_reg <= last2_reg;
            mx3_reg   <= mx2_reg;
            grey3_reg <= grey2_reg;
            hn3_reg   <= hn3_next;
            hlo3_reg  <= hlo3_next;
            hhi3_reg  <= hhi3_next;
            snum3_reg <= snum3_next;
            slo3_reg  <= slo3_next;
            shi3_reg  <= shi3_next;
        end
    end

    // stage 4: compares, key decision and output register
    hsvck_pkg::pixel_t   pix4_reg;
    logic                keyed4_reg, last4_reg;
    logic                hue_ok, sat_ok, val_ok, key_next;
    logic signed [18:0]  hn19, hlo19, hhi19;

    always_comb begin
        hn19  = {hn3_reg[17], hn3_reg};
        hlo19 = $signed({2'b0, hlo3_reg});
        hhi19 = $signed({2'b0, hhi3_reg});
        // grey pixels have hue and saturation both zero
        if (grey3_reg) begin
            hue_ok = (cfg.hue_min == '0);
            sat_ok = (cfg.sat_min == '0);
        end else begin
            hue_ok = (hlo19 <= hn19) && (hn19 <= hhi19);
            sat_ok = (slo3_reg <= snum3_reg) && (snum3_reg <= shi3_reg);
        end
        val_ok   = (cfg.val_min <= mx3_reg) && (mx3_reg <= cfg.val_max);
        key_next = hue_ok && sat_ok && val_ok;
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            pix4_reg   <= key_next ? '0 : pix3_reg;
            keyed4_reg <= key_next;
            last4_reg  <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_pix   = pix4_reg;
    assign out_keyed = keyed4_reg;
    assign out_last  = last4_reg;

endmodule

`default_nettype wire

@@ sv/hsv_range_chroma_key.sv @@
// hsv_range_chroma_key: top level with configuration registers and stream ports
// an accepted request passes stage one to stage four of the datapath before its result reaches the master side
// throughput: one pixel per cycle while m_tready stays high, set by the four-stage datapath with per-stage advance
// a stalled master side fills the empty stages first, then holds s_tready low
// reset (aresetn low, synchronous) empties the pipeline and loads the default ranges
`default_nettype none

module hsv_range_chroma_key (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [hsvck_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [hsvck_pkg::CfgW-1:0]        cfg_wdata,
    // input pixel stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,  // red_in, green_in, blue_in, alpha_in
    input  wire logic                              s_tlast,  // frame_end_in
    // output pixel stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic [0:0]                             m_tuser,  // keyed
    output logic                                   m_tlast   // frame_end_out
);

    hsvck_pkg::key_cfg_t cfg_reg;
    hsvck_pkg::pixel_t   out_pix;
    logic                out_keyed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hue_min <= hsvck_pkg::HueMinRst;
            cfg_reg.hue_max <= hsvck_pkg::HueMaxRst;
            cfg_reg.sat_min <= hsvck_pkg::SatMinRst;
            cfg_reg.sat_max <= hsvck_pkg::SatMaxRst;
            cfg_reg.val_min <= hsvck_pkg::ValMinRst;
            cfg_reg.val_max <= hsvck_pkg::ValMaxRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hsvck_pkg::RegHueMin: cfg_reg.hue_min <= cfg_wdata;
                hsvck_pkg::RegHueMax: cfg_reg.hue_max <= cfg_wdata;
                hsvck_pkg::RegSatMin: cfg_reg.sat_min <= cfg_wdata[7:0];
                hsvck_pkg::RegSatMax: cfg_reg.sat_max <= cfg_wdata[7:0];
                hsvck_pkg::RegValMin: cfg_reg.val_min <= cfg_wdata[7:0];
                hsvck_pkg::RegValMax: cfg_reg.val_max <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    hsvck_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (hsvck_pkg::pixel_t'(s_tdata)),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_keyed (out_keyed),
        .out_last  (m_tlast)
    );

    assign m_tdata    = out_pix;
    assign m_tuser[0] = out_keyed;

endmodule

`default_nettype wire
